FILE: rtl/rtlpm_pkg.sv
// Shared types and constants for the route table longest-prefix-match block.
// Used by rtlpm_table and route_table_longest_prefix_match; depends on nothing.
`default_nettype none

package rtlpm_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int PORT_COUNT  = 4;
  localparam int NUM_IFACE   = 4;

  localparam int ADDR_W    = 32;
  localparam int PORT_W    = 2;
  localparam int SLOT_W    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int IDX_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 40;

  // Item kinds carried on in_tuser.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [ADDR_W-1:0] netmask;
    logic [PORT_W-1:0] port;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    entry_t           entry;
    logic             enable;
  } wr_req_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
  } rd_req_t;

endpackage

`default_nettype wire

FILE: rtl/rtlpm_table.sv
// Route entry storage: a synchronous memory for prefix, mask and port, and
// per-entry valid flops cleared by reset. Depends on rtlpm_pkg.
`default_nettype none

module rtlpm_table (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire rtlpm_pkg::wr_req_t  wr_req,
  input  wire rtlpm_pkg::rd_req_t  rd_req,
  output rtlpm_pkg::entry_t        rd_entry,
  output logic                     rd_enable
);

  rtlpm_pkg::entry_t                 mem [rtlpm_pkg::TABLE_DEPTH];
  logic [rtlpm_pkg::TABLE_DEPTH-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      mem[wr_req.idx] <= wr_req.entry;
    end
    if (rd_req.en) begin
      rd_entry <= mem[rd_req.idx];
    end
  end

  // Valid bits live in flops so reset removes every route at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      rd_enable <= 1'b0;
    end else begin
      if (wr_req.en) begin
        valid_r[wr_req.idx] <= wr_req.enable;
      end
      if (rd_req.en) begin
        rd_enable <= valid_r[rd_req.idx];
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/route_table_longest_prefix_match.sv
// Top level of the route table with longest-prefix-match lookup: stream ports,
// interface address registers, the lookup walker and the result register.
// Depends on rtlpm_pkg and rtlpm_table.
//
//   Channel | Direction | Handshake            | Word
//   in_     | slave     | in_tvalid/in_tready  | in_tuser kind, in_tdata entry/dest
//   out_    | master    | out_tvalid/out_tready| out_tdata lookup result
//   cfg_    | slave     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A write word is stored at the edge that accepts it. A lookup reads one
// entry per cycle from the table memory; its result is loaded into the
// output register once the walk ends, and the next word can be taken in
// the cycle after that, so a lookup holds the input until its result is
// loaded. An interface address hit at any entry ends the walk early.
// Reset clears the valid bits, the interface addresses and all control state.
// A lookup whose result finds the output register still full waits until it
// drains; no new word is taken until the current lookup has been handed over.
// Configuration writes are taken in every cycle.
`default_nettype none

module route_table_longest_prefix_match (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_tvalid,
  output logic                                  in_tready,
  // in_tdata, lowest bit up: entry_slot, entry_prefix, entry_netmask,
  // entry_port, entry_enable, lookup_address, one zero pad bit.
  input  wire [rtlpm_pkg::IN_DATA_W-1:0]        in_tdata,
  // in_tuser: opcode.
  input  wire                                   in_tuser,
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  // out_tdata, lowest bit up: route_found, local_hit, chosen_slot,
  // chosen_port, chosen_prefix.
  output logic [rtlpm_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire [rtlpm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [rtlpm_pkg::ADDR_W-1:0]           cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam logic [rtlpm_pkg::IDX_W-1:0] LAST_IDX =
    rtlpm_pkg::IDX_W'(rtlpm_pkg::TABLE_DEPTH - 1);

  // Input word fields.
  logic [rtlpm_pkg::SLOT_W-1:0] entry_slot;
  logic [rtlpm_pkg::ADDR_W-1:0] entry_prefix;
  logic [rtlpm_pkg::ADDR_W-1:0] entry_netmask;
  logic [rtlpm_pkg::PORT_W-1:0] entry_port;
  logic                         entry_enable;
  logic [rtlpm_pkg::ADDR_W-1:0] lookup_address;

  assign entry_slot     = in_tdata[3:0];
  assign entry_prefix   = in_tdata[35:4];
  assign entry_netmask  = in_tdata[67:36];
  assign entry_port     = in_tdata[69:68];
  assign entry_enable   = in_tdata[70];
  assign lookup_address = in_tdata[102:71];

  logic [1:0]                   state_r, state_nxt;
  logic [rtlpm_pkg::ADDR_W-1:0] iface_r [rtlpm_pkg::NUM_IFACE];
  logic [rtlpm_pkg::ADDR_W-1:0] dest_r;
  logic [rtlpm_pkg::IDX_W-1:0]  rd_idx_r, cmp_idx_r;
  logic                         rd_busy_r, cmp_vld_r;
  logic [rtlpm_pkg::ADDR_W-1:0] best_mask_r;
  logic                         found_r, local_r;
  logic [rtlpm_pkg::IDX_W-1:0]  pick_r;
  logic [rtlpm_pkg::PORT_W-1:0] pick_port_r;
  logic [rtlpm_pkg::ADDR_W-1:0] pick_prefix_r;

  rtlpm_pkg::wr_req_t wr_req;
  rtlpm_pkg::rd_req_t rd_req;
  rtlpm_pkg::entry_t  rd_entry;
  logic               rd_enable;

  logic in_acc, wr_acc, lk_acc, out_free;
  logic hit_local, hit_prefix, walk_end;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign wr_acc    = in_acc && (in_tuser == rtlpm_pkg::OP_WRITE);
  assign lk_acc    = in_acc && (in_tuser == rtlpm_pkg::OP_LOOKUP);
  assign out_free  = !out_tvalid || out_tready;

  // Writes happen only in the idle state, so they never overlap a walk.
  always_comb begin
    wr_req.en = wr_acc &&
                ({5'd0, entry_slot} < 9'(rtlpm_pkg::TABLE_DEPTH));
    wr_req.idx           = rtlpm_pkg::IDX_W'(entry_slot);
    wr_req.entry.prefix  = entry_prefix;
    wr_req.entry.netmask = entry_netmask;
    wr_req.entry.port    = entry_port;
    wr_req.enable        = entry_enable;
  end

  rtlpm_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_req    (wr_req),
    .rd_req    (rd_req),
    .rd_entry  (rd_entry),
    .rd_enable (rd_enable)
  );

  // Compare stage for the entry whose read data arrived this cycle.
  always_comb begin
    hit_local = cmp_vld_r && rd_enable &&
                ({1'b0, rd_entry.port} < 3'(rtlpm_pkg::PORT_COUNT)) &&
                (dest_r == iface_r[rd_entry.port]);
    hit_prefix = cmp_vld_r && rd_enable && !hit_local &&
                 (((rd_entry.prefix ^ dest_r) & rd_entry.netmask) == '0) &&
                 (best_mask_r <= rd_entry.netmask);
    walk_end  = hit_local || (cmp_vld_r && (cmp_idx_r == LAST_IDX));
    rd_req.en  = (state_r == S_WALK) && rd_busy_r && !hit_local;
    rd_req.idx = rd_idx_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (lk_acc) state_nxt = S_WALK;
      end
      S_WALK: begin
        if (walk_end) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      rd_busy_r  <= 1'b0;
      cmp_vld_r  <= 1'b0;
      out_tvalid <= 1'b0;
      for (int i = 0; i < rtlpm_pkg::NUM_IFACE; i++) begin
        iface_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= rd_req.en;
      if (cfg_valid && cfg_ready) begin
        iface_r[cfg_index] <= cfg_data;
      end
      if (lk_acc) begin
        rd_busy_r <= 1'b1;
      end else if (rd_req.en && (rd_idx_r == LAST_IDX)) begin
        rd_busy_r <= 1'b0;
      end else if (hit_local) begin
        rd_busy_r <= 1'b0;
      end
      if ((state_r == S_DONE) && out_free) begin
        out_tvalid <= 1'b1;
      end else if (out_tvalid && out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  // Walk datapath; a lookup start clears the running best.
  always_ff @(posedge clk) begin
    if (lk_acc) begin
      dest_r        <= lookup_address;
      rd_idx_r      <= '0;
      best_mask_r   <= '0;
      found_r       <= 1'b0;
      local_r       <= 1'b0;
      pick_r        <= '0;
      pick_port_r   <= '0;
      pick_prefix_r <= '0;
    end else begin
      if (rd_req.en) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
      if (hit_local || hit_prefix) begin
        found_r       <= 1'b1;
        pick_r        <= cmp_idx_r;
        pick_port_r   <= rd_entry.port;
        pick_prefix_r <= rd_entry.prefix;
      end
      if (hit_local) begin
        local_r <= 1'b1;
      end
      if (hit_prefix) begin
        best_mask_r <= rd_entry.netmask;
      end
    end
    if (rd_req.en) begin
      cmp_idx_r <= rd_idx_r;
    end
    if ((state_r == S_DONE) && out_free) begin
      out_tdata <= {pick_prefix_r, pick_port_r,
                    rtlpm_pkg::SLOT_W'(pick_r), local_r, found_r};
    end
  end

  a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    wr_req.en |-> (state_r == S_IDLE))
    else $error("table write outside the idle state");

  a_walk_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    lk_acc |=> (state_r == S_WALK) && (rd_idx_r == '0) && rd_busy_r)
    else $error("lookup did not start its walk at entry zero");

  a_cmp_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    rd_req.en |=> cmp_vld_r && (cmp_idx_r == $past(rd_idx_r)))
    else $error("compare stage lost track of the read index");

  a_local_implies_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && local_r |-> found_r)
    else $error("local hit without a found route");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside the report state");

endmodule

`default_nettype wire

FILE: bench/tb_route_table_longest_prefix_match.sv
`timescale 1ns / 1ps
// Self-checking bench for route_table_longest_prefix_match: drives write and lookup
// words with random flow control and checks every lookup result against a
// scoreboard that keeps its own route table. Depends on rtlpm_pkg and the block.

typedef struct packed {
  logic                             pad;
  logic [rtlpm_pkg::ADDR_W-1:0]     lookup_address;
  logic                             enable;
  logic [rtlpm_pkg::PORT_W-1:0]     port;
  logic [rtlpm_pkg::ADDR_W-1:0]     netmask;
  logic [rtlpm_pkg::ADDR_W-1:0]     prefix;
  logic [rtlpm_pkg::SLOT_W-1:0]     slot;
} route_word_t;

typedef struct packed {
  logic [rtlpm_pkg::ADDR_W-1:0]     prefix;
  logic [rtlpm_pkg::PORT_W-1:0]     port;
  logic [rtlpm_pkg::SLOT_W-1:0]     slot;
  logic                             local_hit;
  logic                             found;
} route_res_t;

class route_checker;
  rtlpm_pkg::entry_t              routes[rtlpm_pkg::TABLE_DEPTH];
  bit                             route_on[rtlpm_pkg::TABLE_DEPTH];
  logic [rtlpm_pkg::ADDR_W-1:0]   iface_addr[rtlpm_pkg::NUM_IFACE];
  route_res_t                     pending_routes[$];
  int                             errors;

  function void clear();
    for (int i = 0; i < rtlpm_pkg::TABLE_DEPTH; i++) begin
      routes[i] = '0;
      route_on[i] = 1'b0;
    end
    for (int i = 0; i < rtlpm_pkg::NUM_IFACE; i++) iface_addr[i] = '0;
    pending_routes.delete();
    errors = 0;
  endfunction

  function void set_iface(logic [rtlpm_pkg::CFG_IDX_W-1:0] idx,
                          logic [rtlpm_pkg::ADDR_W-1:0] val);
    iface_addr[idx] = val;
  endfunction

  // Walk the enabled entries in slot order; an interface address hit ends
  // the walk, otherwise a later match with a mask at least as large wins.
  function route_res_t predict_route(logic [rtlpm_pkg::ADDR_W-1:0] dest);
    route_res_t                   res;
    logic [rtlpm_pkg::ADDR_W-1:0] best_mask;
    logic [rtlpm_pkg::ADDR_W-1:0] m;
    int                           pick;
    res = '0;
    best_mask = '0;
    pick = -1;
    for (int i = 0; i < rtlpm_pkg::TABLE_DEPTH; i++) begin
      if (!route_on[i]) continue;
      if (routes[i].port < rtlpm_pkg::PORT_COUNT && dest == iface_addr[routes[i].port]) begin
        res.local_hit = 1'b1;
        pick = i;
        break;
      end
      m = routes[i].netmask;
      if ((routes[i].prefix & m) == (dest & m) && best_mask <= m) begin
        best_mask = m;
        pick = i;
      end
    end
    if (pick >= 0) begin
      res.found = 1'b1;
      res.slot = pick[rtlpm_pkg::SLOT_W-1:0];
      res.port = routes[pick].port;
      res.prefix = routes[pick].prefix;
    end
    return res;
  endfunction

  function void note_word(logic op, route_word_t w);
    if (op == rtlpm_pkg::OP_WRITE) begin
      if (w.slot < rtlpm_pkg::TABLE_DEPTH) begin
        routes[w.slot].prefix = w.prefix;
        routes[w.slot].netmask = w.netmask;
        routes[w.slot].port = w.port;
        route_on[w.slot] = w.enable;
      end
    end else begin
      pending_routes.push_back(predict_route(w.lookup_address));
    end
  endfunction

  function void check_result(route_res_t got);
    route_res_t want;
    if (pending_routes.size() == 0) begin
      $display("%0t: result with no lookup pending, expected none, actual %h", $time, got);
      errors++;
      return;
    end
    want = pending_routes.pop_front();
    if (got.found !== want.found) begin
      $display("%0t: route_found expected %0h actual %0h", $time, want.found, got.found);
      errors++;
    end
    if (got.local_hit !== want.local_hit) begin
      $display("%0t: local_hit expected %0h actual %0h", $time, want.local_hit, got.local_hit);
      errors++;
    end
    if (got.slot !== want.slot) begin
      $display("%0t: chosen_slot expected %0d actual %0d", $time, want.slot, got.slot);
      errors++;
    end
    if (got.port !== want.port) begin
      $display("%0t: chosen_port expected %0d actual %0d", $time, want.port, got.port);
      errors++;
    end
    if (got.prefix !== want.prefix) begin
      $display("%0t: chosen_prefix expected %h actual %h", $time, want.prefix, got.prefix);
      errors++;
    end
  endfunction
endclass

module tb_route_table_longest_prefix_match;
  import rtlpm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_IFACE0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IFACE1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IFACE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IFACE3 = 2'd3;

  localparam int LOOKUP_CYCLES = TABLE_DEPTH + 3;
  localparam int SETTLE_CYCLES = 2 * LOOKUP_CYCLES;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASES        = 8;
  localparam int PHASE_WORDS   = 200;
  localparam int CYCLE_LIMIT   = 400000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata = '0;
  logic                   in_tuser = OP_WRITE;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_IFACE0;
  logic [ADDR_W-1:0]      cfg_data = '0;

  route_checker sb;
  int  burst_left = 0;
  int  hold_left = 0;
  bit  hold_off_go = 1'b0;
  int  rx_cycle = 0;
  int  cycles = 0;

  route_table_longest_prefix_match DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Results are checked before the input word of the same edge is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(route_res_t'(out_tdata));
      if (in_tvalid && in_tready) sb.note_word(in_tuser, route_word_t'(in_tdata));
      if (cfg_valid && cfg_ready) sb.set_iface(cfg_index, cfg_data);
    end
  end

  // Receiver: a stall pattern that rotates through four modes, plus a
  // long hold-off whenever the stimulus asks for one.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready = 1'b0;
    end else begin
      rx_cycle++;
      if (hold_off_go) begin
        hold_off_go = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready = 1'b0;
      end else begin
        case ((rx_cycle / 700) % 4)
          0: out_tready = 1'b1;
          1: out_tready = ($urandom_range(0, 3) != 0);
          2: out_tready = ((rx_cycle % 7) < 4);
          default: out_tready = 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  task automatic send_word(input logic op, input route_word_t w);
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_tuser = op;
    in_tdata = w;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic put_entry(input logic [SLOT_W-1:0] slot, input logic [ADDR_W-1:0] prefix,
                           input logic [ADDR_W-1:0] mask, input logic [PORT_W-1:0] port,
                           input logic enable);
    route_word_t w;
    w.pad = 1'b0;
    w.lookup_address = $urandom;
    w.enable = enable;
    w.port = port;
    w.netmask = mask;
    w.prefix = prefix;
    w.slot = slot;
    send_word(OP_WRITE, w);
  endtask

  task automatic put_lookup(input logic [ADDR_W-1:0] dest);
    route_word_t w;
    w = {$urandom, $urandom, $urandom, 8'($urandom)};
    w.pad = 1'b0;
    w.lookup_address = dest;
    send_word(OP_LOOKUP, w);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_ifaces(input logic [ADDR_W-1:0] a0, input logic [ADDR_W-1:0] a1,
                            input logic [ADDR_W-1:0] a2, input logic [ADDR_W-1:0] a3);
    write_reg(REG_IFACE0, a0);
    write_reg(REG_IFACE1, a1);
    write_reg(REG_IFACE2, a2);
    write_reg(REG_IFACE3, a3);
  endtask

  // Stop sending, wait for every outstanding lookup, then let the walker settle.
  task automatic drain_lookups();
    in_tvalid = 1'b0;
    burst_left = 0;
    while (sb.pending_routes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // An address inside some enabled route, with random host bits; a random address if no route is enabled.
  function automatic logic [ADDR_W-1:0] near_route();
    int          live[$];
    int          k;
    logic [ADDR_W-1:0] m;
    for (int i = 0; i < TABLE_DEPTH; i++) if (sb.route_on[i]) live.push_back(i);
    if (live.size() == 0) return $urandom;
    k = live[$urandom_range(0, live.size() - 1)];
    m = sb.routes[k].netmask;
    return (sb.routes[k].prefix & m) | ($urandom & ~m);
  endfunction

  function automatic logic [ADDR_W-1:0] random_mask();
    int len;
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      len = $urandom_range(0, 32);
      return (len == 0) ? '0 : ({ADDR_W{1'b1}} << (32 - len));
    end
    if (r == 7) return {ADDR_W{1'b1}};
    return $urandom;
  endfunction

  task automatic random_word();
    int r;
    if ($urandom_range(0, 9) < 3) begin
      put_entry(SLOT_W'($urandom_range(0, TABLE_DEPTH - 1)), $urandom, random_mask(),
                PORT_W'($urandom_range(0, 3)), $urandom_range(0, 99) < 85);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 25)      put_lookup(sb.iface_addr[$urandom_range(0, NUM_IFACE - 1)]);
      else if (r < 70) put_lookup(near_route());
      else if (r < 75) put_lookup($urandom_range(0, 1) ? {ADDR_W{1'b1}} : '0);
      else             put_lookup($urandom);
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] v;
    sb = new;
    sb.clear();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty table: no route, even for an interface address.
    put_lookup('0);
    put_lookup(32'h0102_0304);
    drain_lookups();
    set_ifaces(32'h0A00_0001, 32'hC0A8_0001, 32'hFFFF_FFFF, 32'h0000_0000);

    put_entry(4'd0, 32'h0000_0000, 32'h0000_0000, 2'd0, 1'b1);
    put_entry(4'd15, 32'h0A00_0000, 32'hFF00_0000, 2'd1, 1'b1);
    put_entry(4'd7, 32'h0A01_0000, 32'hFFFF_0000, 2'd3, 1'b1);
    // Equal mask in a later slot takes over.
    put_entry(4'd8, 32'h0A01_0000, 32'hFFFF_0000, 2'd2, 1'b1);
    put_lookup(32'h0A01_0203);
    put_lookup(32'h0A7F_0000);
    put_lookup(32'h0B00_0000);
    put_lookup(32'hC0A8_0001);
    put_lookup(32'hFFFF_FFFF);
    put_lookup(32'h0000_0000);
    put_entry(4'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd0, 1'b1);
    put_lookup(32'hFFFF_FFFF);
    put_entry(4'd8, 32'h0A01_0000, 32'hFFFF_0000, 2'd2, 1'b0);
    put_lookup(32'hFFFF_FFFF);
    put_lookup(32'h0A01_FFFF);
    put_entry(4'd5, 32'hFFFF_FFFF, 32'h00FF_00FF, 2'd3, 1'b1);
    put_lookup(32'h12FF_34FF);
    put_entry(4'd0, 32'h0000_0000, 32'h0000_0000, 2'd0, 1'b0);
    put_lookup(32'h0B00_0000);
    put_lookup(32'h0000_0000);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_lookups();
      v = $urandom;
      case (phase)
        0: set_ifaces($urandom, $urandom, $urandom, $urandom);
        1: set_ifaces('0, '0, '0, '0);
        2: set_ifaces({ADDR_W{1'b1}}, {ADDR_W{1'b1}}, {ADDR_W{1'b1}}, {ADDR_W{1'b1}});
        3: set_ifaces(v, v, v, v);
        4: set_ifaces('0, {ADDR_W{1'b1}}, $urandom, $urandom);
        5: set_ifaces(near_route(), near_route(), near_route(), near_route());
        6: set_ifaces($urandom, $urandom, $urandom, $urandom);
        default: set_ifaces({ADDR_W{1'b1}}, '0, near_route(), $urandom);
      endcase
      // Hold the receiver off while words keep coming so the input backs up.
      if (phase == 2 || phase == 5) hold_off_go = 1'b1;
      repeat (PHASE_WORDS) random_word();
    end

    drain_lookups();
    if (sb.errors == 0 && sb.pending_routes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
